// ===== rtl/qrm_pkg.sv =====
// ----------------------------------------------------------------------------
// qrm_pkg
// shared types and constants of the quaternion to rotation matrix block
// ----------------------------------------------------------------------------
package qrm_pkg;

    localparam int QRM_FRAC_BITS = 14;
    localparam int WORD_W        = 16;
    localparam int NUM_LANES     = 9;
    localparam int PROD_W        = 32;
    localparam int SUM_W         = 35;
    localparam int MAG_W         = 33;
    localparam int REM_W         = 34;

    localparam int LANE_R00 = 0;
    localparam int LANE_R01 = 1;
    localparam int LANE_R02 = 2;
    localparam int LANE_R10 = 3;
    localparam int LANE_R11 = 4;
    localparam int LANE_R12 = 5;
    localparam int LANE_R20 = 6;
    localparam int LANE_R21 = 7;
    localparam int LANE_R22 = 8;

    typedef struct packed {
        logic signed [WORD_W-1:0] qx;
        logic signed [WORD_W-1:0] qy;
        logic signed [WORD_W-1:0] qz;
        logic signed [WORD_W-1:0] qw;
    } quat_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] r00;
        logic signed [WORD_W-1:0] r01;
        logic signed [WORD_W-1:0] r02;
        logic signed [WORD_W-1:0] r10;
        logic signed [WORD_W-1:0] r11;
        logic signed [WORD_W-1:0] r12;
        logic signed [WORD_W-1:0] r20;
        logic signed [WORD_W-1:0] r21;
        logic signed [WORD_W-1:0] r22;
    } mat_t;

    typedef struct packed {
        logic                 zero;
        logic [NUM_LANES-1:0] neg;
    } side_t;

endpackage

// ===== rtl/qrm_stream_if.sv =====
// ----------------------------------------------------------------------------
// qrm_stream_if
// valid/ready channel carrying one word
// ----------------------------------------------------------------------------
interface qrm_stream_if #(parameter type word_t = logic);

    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

// ===== rtl/qrm_divider.sv =====
// ----------------------------------------------------------------------------
// qrm_divider
// nine-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module qrm_divider #(
    parameter int FRAC_BITS = qrm_pkg::QRM_FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           valid_in,
    input  logic [qrm_pkg::MAG_W-1:0]      mag_in [qrm_pkg::NUM_LANES],
    input  logic [qrm_pkg::MAG_W-1:0]      n_in,
    input  qrm_pkg::side_t                 side_in,
    output logic                           valid_out,
    output logic [FRAC_BITS+1:0]           q_out [qrm_pkg::NUM_LANES],
    output qrm_pkg::side_t                 side_out
);
    import qrm_pkg::*;

    localparam int QW     = FRAC_BITS + 2;
    localparam int STAGES = QW;

    logic             v_reg    [STAGES];
    logic [MAG_W-1:0] n_reg    [STAGES];
    side_t            side_reg [STAGES];
    logic [REM_W-1:0] rem_reg  [STAGES][NUM_LANES];
    logic [QW-1:0]    q_reg    [STAGES][NUM_LANES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [REM_W-1:0] rem_next [NUM_LANES];
        logic [QW-1:0]    q_next   [NUM_LANES];
        logic [MAG_W-1:0] n_src;

        if (s == 0) begin : g_first
            assign n_src = n_in;
        end else begin : g_rest
            assign n_src = n_reg[s-1];
        end

        always_comb
        begin
            logic [REM_W-1:0] trial;
            logic             qbit;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                if (s == 0)
                begin
                    trial = REM_W'(mag_in[i]);
                end
                else
                begin
                    trial = rem_reg[(s == 0) ? 0 : s-1][i] << 1;
                end
                qbit = (trial >= REM_W'(n_src));
                rem_next[i] = qbit ? (trial - REM_W'(n_src)) : trial;
                if (s == 0)
                begin
                    q_next[i] = QW'(qbit);
                end
                else
                begin
                    q_next[i] = {q_reg[(s == 0) ? 0 : s-1][i][QW-2:0], qbit};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= (s == 0) ? valid_in : v_reg[(s == 0) ? 0 : s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[s]    <= n_src;
                side_reg[s] <= (s == 0) ? side_in : side_reg[(s == 0) ? 0 : s-1];
                rem_reg[s]  <= rem_next;
                q_reg[s]    <= q_next;
            end
        end
    end

    assign valid_out = v_reg[STAGES-1];
    assign q_out     = q_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

// ===== rtl/quaternion_to_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// rotation matrix of a quaternion, entries rounded and saturated to fixed point
// ----------------------------------------------------------------------------
//   port  dir  word                          handshake
//   quat  in   qx qy qz qw, signed Q1.14     valid/ready
//   mat   out  r00 .. r22, signed Q1.F       valid/ready
//
// one word enters per cycle while the pipeline is not held; the restoring divider
// resolves one quotient bit per stage
// the whole pipeline holds while a result waits at the output register
// reset clears the valid bits only
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix #(
    parameter int FRAC_BITS = qrm_pkg::QRM_FRAC_BITS
) (
    input logic          clk,
    input logic          rst_n,
    qrm_stream_if.sink   quat,
    qrm_stream_if.source mat
);
    import qrm_pkg::*;

    localparam int QW    = FRAC_BITS + 2;
    localparam int ONE_I = (FRAC_BITS > 14) ? 32767 : (1 << FRAC_BITS);
    localparam logic [WORD_W-1:0] ONE_W = WORD_W'(ONE_I);
    localparam logic [QW-1:0]     ONE_Q = QW'(1) << FRAC_BITS;

    logic en;

    logic  v0_reg;
    quat_t q0_reg;

    logic v1_reg;
    logic signed [PROD_W-1:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [PROD_W-1:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;

    logic             v2_reg;
    logic [MAG_W-1:0] n2_reg;
    side_t            side2_reg;
    logic [MAG_W-1:0] mag2_reg [NUM_LANES];

    logic signed [SUM_W-1:0] nn_next;
    logic signed [SUM_W-1:0] num_next [NUM_LANES];
    logic [MAG_W-1:0]        mag_next [NUM_LANES];
    side_t                   side_next;

    logic          dv_valid;
    logic [QW-1:0] dv_q [NUM_LANES];
    side_t         dv_side;

    logic [WORD_W-1:0] res [NUM_LANES];
    logic              mat_valid_reg;
    mat_t              mat_data_reg;
    mat_t              mat_next;

    assign en         = !mat_valid_reg || mat.ready;
    assign quat.ready = en;
    assign mat.valid  = mat_valid_reg;
    assign mat.data   = mat_data_reg;

    // valid bits of the input, product and norm registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= quat.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0_reg <= quat.data;
            xx_reg <= q0_reg.qx * q0_reg.qx;
            yy_reg <= q0_reg.qy * q0_reg.qy;
            zz_reg <= q0_reg.qz * q0_reg.qz;
            ww_reg <= q0_reg.qw * q0_reg.qw;
            xy_reg <= q0_reg.qx * q0_reg.qy;
            wz_reg <= q0_reg.qw * q0_reg.qz;
            xz_reg <= q0_reg.qx * q0_reg.qz;
            wy_reg <= q0_reg.qw * q0_reg.qy;
            yz_reg <= q0_reg.qy * q0_reg.qz;
            wx_reg <= q0_reg.qw * q0_reg.qx;
        end
    end

    // norm and numerators
    always_comb
    begin
        nn_next = SUM_W'(xx_reg) + SUM_W'(yy_reg) + SUM_W'(zz_reg) + SUM_W'(ww_reg);
        num_next[LANE_R00] = nn_next - ((SUM_W'(yy_reg) + SUM_W'(zz_reg)) <<< 1);
        num_next[LANE_R01] = (SUM_W'(xy_reg) - SUM_W'(wz_reg)) <<< 1;
        num_next[LANE_R02] = (SUM_W'(xz_reg) + SUM_W'(wy_reg)) <<< 1;
        num_next[LANE_R10] = (SUM_W'(xy_reg) + SUM_W'(wz_reg)) <<< 1;
        num_next[LANE_R11] = nn_next - ((SUM_W'(xx_reg) + SUM_W'(zz_reg)) <<< 1);
        num_next[LANE_R12] = (SUM_W'(yz_reg) - SUM_W'(wx_reg)) <<< 1;
        num_next[LANE_R20] = (SUM_W'(xz_reg) - SUM_W'(wy_reg)) <<< 1;
        num_next[LANE_R21] = (SUM_W'(yz_reg) + SUM_W'(wx_reg)) <<< 1;
        num_next[LANE_R22] = nn_next - ((SUM_W'(xx_reg) + SUM_W'(yy_reg)) <<< 1);
        side_next.zero = (nn_next == '0);
        for (int i = 0; i < NUM_LANES; i++)
        begin
            side_next.neg[i] = num_next[i][SUM_W-1];
            mag_next[i] = num_next[i][SUM_W-1] ? MAG_W'(-num_next[i]) : MAG_W'(num_next[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_reg    <= MAG_W'(nn_next);
            side2_reg <= side_next;
            mag2_reg  <= mag_next;
        end
    end

    qrm_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (v2_reg),
        .mag_in    (mag2_reg),
        .n_in      (n2_reg),
        .side_in   (side2_reg),
        .valid_out (dv_valid),
        .q_out     (dv_q),
        .side_out  (dv_side)
    );

    // round, saturate, identity for a zero quaternion
    always_comb
    begin
        logic [QW:0]   inc;
        logic [QW-1:0] qr;
        logic [31:0]   m;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            inc = {1'b0, dv_q[i]} + (QW+1)'(1);
            qr  = inc[QW:1];
            if (qr > ONE_Q)
            begin
                qr = ONE_Q;
            end
            m = 32'(qr);
            if (dv_side.neg[i])
            begin
                if (m > 32'd32768)
                begin
                    m = 32'd32768;
                end
                res[i] = WORD_W'(-m);
            end
            else
            begin
                if (m > 32'd32767)
                begin
                    m = 32'd32767;
                end
                res[i] = WORD_W'(m);
            end
            if (dv_side.zero)
            begin
                res[i] = (i == LANE_R00 || i == LANE_R11 || i == LANE_R22) ? ONE_W : '0;
            end
        end
        mat_next.r00 = res[LANE_R00];
        mat_next.r01 = res[LANE_R01];
        mat_next.r02 = res[LANE_R02];
        mat_next.r10 = res[LANE_R10];
        mat_next.r11 = res[LANE_R11];
        mat_next.r12 = res[LANE_R12];
        mat_next.r20 = res[LANE_R20];
        mat_next.r21 = res[LANE_R21];
        mat_next.r22 = res[LANE_R22];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mat_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mat_data_reg <= mat_next;
        end
    end

    // the pipeline only holds for a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !quat.ready |-> (mat.valid && !mat.ready))
        else $error("pipeline held without a waiting result");

    a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
        mat.valid |-> ($signed(mat.data.r00) <= ONE_I && $signed(mat.data.r00) >= -ONE_I
                    && $signed(mat.data.r11) <= ONE_I && $signed(mat.data.r11) >= -ONE_I))
        else $error("diagonal entry out of range");

    a_offdiag_range: assert property (@(posedge clk) disable iff (!rst_n)
        mat.valid |-> ($signed(mat.data.r01) <= ONE_I && $signed(mat.data.r01) >= -ONE_I
                    && $signed(mat.data.r12) <= ONE_I && $signed(mat.data.r12) >= -ONE_I))
        else $error("off-diagonal entry out of range");

endmodule
